[hdl/sisp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Steering PID package
// Widths, codes, microcode word layout and the band gain function shared by
// the steering PID sequencer, microcode ROM and datapath.
// ----------------------------------------------------------------------------
package sisp_pkg;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 20;
  localparam int DUTY_W         = 15;
  localparam int ERR_W          = 16;
  localparam int MODE_W         = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 20;
  localparam int STEP_W         = 3;

  localparam int DIFF_W  = ERR_W + 2;
  localparam int PROD_W  = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int MAG_W   = ACC_W - 1;
  localparam int BAND_W  = 4;
  localparam int SCALE_W = MAG_W + BAND_W;
  localparam int SMAG_W  = SCALE_W - GAIN_FRAC_BITS;
  localparam int IPART_W = MAG_W - GAIN_FRAC_BITS;
  localparam int SAT_W   = ERR_W;
  localparam int SUM_W   = ERR_W + 2;

  localparam logic [SMAG_W-1:0] SAT_POS = SMAG_W'(2 ** (ERR_W - 1) - 1);
  localparam logic [SMAG_W-1:0] SAT_NEG = SMAG_W'(2 ** (ERR_W - 1));

  localparam logic [IPART_W-1:0] BAND_LIMIT_1 = IPART_W'(10);
  localparam logic [IPART_W-1:0] BAND_LIMIT_2 = IPART_W'(30);
  localparam logic [IPART_W-1:0] BAND_LIMIT_3 = IPART_W'(60);
  localparam logic [BAND_W-1:0]  BAND_GAIN_1  = BAND_W'(6);
  localparam logic [BAND_W-1:0]  BAND_GAIN_2  = BAND_W'(7);
  localparam logic [BAND_W-1:0]  BAND_GAIN_3  = BAND_W'(9);
  localparam logic [BAND_W-1:0]  BAND_GAIN_4  = BAND_W'(10);

  localparam logic [GAIN_W-1:0] KP_RESET    = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] KI_RESET    = GAIN_W'(22938);
  localparam logic [GAIN_W-1:0] KD_RESET    = GAIN_W'(655);
  localparam logic [DUTY_W-1:0] CENTER_RESET = DUTY_W'(0);
  localparam logic [DUTY_W-1:0] LEFT_RESET   = DUTY_W'(0);
  localparam logic [DUTY_W-1:0] RIGHT_RESET  = DUTY_W'(32767);

  localparam logic [MODE_W-1:0] MODE_NORMAL = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_LEFT   = MODE_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_KP     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KI     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KD     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = CFG_IDX_W'(5);

  localparam logic [STEP_W-1:0] STEP_FINISH = STEP_W'(6);

  typedef enum logic [1:0] {
    MUL_KP,
    MUL_KI,
    MUL_KD
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    logic              mag_en;
    logic              scale_en;
    logic              jump_hold;
    logic              last;
    logic [STEP_W-1:0] jump_to;
  } ucode_t;

  typedef struct packed {
    logic     load;
    logic     fire;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     mag_en;
    logic     scale_en;
  } dp_ctl_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [DUTY_W-1:0] center;
    logic [DUTY_W-1:0] left;
    logic [DUTY_W-1:0] right;
  } cfg_t;

  function automatic logic [BAND_W-1:0] band_gain(input logic [IPART_W-1:0] ipart);
    logic [BAND_W-1:0] g;
    if (ipart <= BAND_LIMIT_1) begin
      g = BAND_GAIN_1;
    end else if (ipart <= BAND_LIMIT_2) begin
      g = BAND_GAIN_2;
    end else if (ipart <= BAND_LIMIT_3) begin
      g = BAND_GAIN_3;
    end else begin
      g = BAND_GAIN_4;
    end
    return g;
  endfunction

endpackage
`default_nettype wire

[hdl/servo_incremental_pid_steering_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Servo incremental PID steering unit
// The microcode program runs the three gain products on one shared multiplier;
// hold modes jump from the first step straight to the finish step. A new input
// transaction is taken only once the previous result is in the output register.
// Reset restores the default gains, center and limits, clears the error
// history, and leaves the unit idle with no result pending.
// ----------------------------------------------------------------------------
module servo_incremental_pid_steering_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sisp_pkg::MODE_W-1:0]     steer_mode,
  input  wire logic [sisp_pkg::ERR_W-1:0]      err_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [sisp_pkg::DUTY_W-1:0]     duty,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sisp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sisp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sisp_pkg::*;

  cfg_t    cfg;
  dp_ctl_t ctl;
  logic    hold_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp     <= KP_RESET;
      cfg.ki     <= KI_RESET;
      cfg.kd     <= KD_RESET;
      cfg.center <= CENTER_RESET;
      cfg.left   <= LEFT_RESET;
      cfg.right  <= RIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KP:     cfg.kp     <= cfg_data[GAIN_W-1:0];
        REG_KI:     cfg.ki     <= cfg_data[GAIN_W-1:0];
        REG_KD:     cfg.kd     <= cfg_data[GAIN_W-1:0];
        REG_CENTER: cfg.center <= cfg_data[DUTY_W-1:0];
        REG_LEFT:   cfg.left   <= cfg_data[DUTY_W-1:0];
        REG_RIGHT:  cfg.right  <= cfg_data[DUTY_W-1:0];
        default:    cfg.kp     <= cfg.kp;
      endcase
    end
  end

  sisp_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hold_mode (hold_mode),
    .ctl       (ctl)
  );

  sisp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cfg        (cfg),
    .steer_mode (steer_mode),
    .err_sample (err_sample),
    .hold_mode  (hold_mode),
    .duty       (duty)
  );

endmodule
`default_nettype wire

[hdl/sisp_ucode_rom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Steering PID microcode ROM
// Read-only control program: one control word per step of the sequencer.
// ----------------------------------------------------------------------------
module sisp_ucode_rom (
  input  wire logic [sisp_pkg::STEP_W-1:0] step,
  output sisp_pkg::ucode_t                 word
);
  import sisp_pkg::*;

  always_comb begin
    word = '{mul_sel: MUL_KP, acc_op: ACC_HOLD, mag_en: 1'b0, scale_en: 1'b0,
             jump_hold: 1'b0, last: 1'b0, jump_to: '0};
    case (step)
      STEP_W'(0): begin
        word.mul_sel   = MUL_KP;
        word.acc_op    = ACC_CLEAR;
        word.jump_hold = 1'b1;
        word.jump_to   = STEP_FINISH;
      end
      STEP_W'(1): begin
        word.mul_sel = MUL_KI;
        word.acc_op  = ACC_ADD;
      end
      STEP_W'(2): begin
        word.mul_sel = MUL_KD;
        word.acc_op  = ACC_ADD;
      end
      STEP_W'(3): begin
        word.acc_op = ACC_ADD;
      end
      STEP_W'(4): begin
        word.mag_en = 1'b1;
      end
      STEP_W'(5): begin
        word.scale_en = 1'b1;
      end
      default: begin
        word.last = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/sisp_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Steering PID sequencer
// Step counter with conditional jump, input and output handshake control.
// ----------------------------------------------------------------------------
module sisp_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire logic        hold_mode,
  output sisp_pkg::dp_ctl_t ctl
);
  import sisp_pkg::*;

  logic              busy;
  logic              busy_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid_next;
  logic              out_free;
  ucode_t            word;

  sisp_ucode_rom u_rom (
    .step (step),
    .word (word)
  );

  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (!busy) begin
      if (in_valid) begin
        busy_next = 1'b1;
        step_next = '0;
      end
    end else if (word.last) begin
      if (out_free) begin
        busy_next = 1'b0;
      end
    end else if (word.jump_hold && hold_mode) begin
      step_next = word.jump_to;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_comb begin
    ctl.load     = !busy && in_valid;
    ctl.fire     = busy && word.last && out_free;
    ctl.mul_sel  = word.mul_sel;
    ctl.acc_op   = busy ? word.acc_op : ACC_HOLD;
    ctl.mag_en   = busy && word.mag_en;
    ctl.scale_en = busy && word.scale_en;
    out_valid_next = ctl.fire || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

[hdl/sisp_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Steering PID datapath
// Shared gain multiplier, accumulator, band scaling, saturation and clamp,
// error history and the output duty register.
// ----------------------------------------------------------------------------
module sisp_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sisp_pkg::dp_ctl_t            ctl,
  input  wire sisp_pkg::cfg_t               cfg,
  input  wire logic [sisp_pkg::MODE_W-1:0]  steer_mode,
  input  wire logic [sisp_pkg::ERR_W-1:0]   err_sample,
  output logic                              hold_mode,
  output logic      [sisp_pkg::DUTY_W-1:0]  duty
);
  import sisp_pkg::*;

  logic        [MODE_W-1:0]  mode_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [ERR_W-1:0]   err_prev;
  logic signed [ERR_W-1:0]   err_prev2;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic        [MAG_W-1:0]   mag;
  logic                      neg;
  logic        [SCALE_W-1:0] scaled;

  logic signed [DIFF_W-1:0]  d1;
  logic signed [DIFF_W-1:0]  d2;
  logic signed [DIFF_W-1:0]  e_ext;
  logic signed [DIFF_W-1:0]  mul_b;
  logic        [GAIN_W-1:0]  mul_a;
  logic        [SMAG_W-1:0]  smag;
  logic        [SAT_W-1:0]   sat;
  logic signed [SUM_W-1:0]   corr;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   lo;
  logic signed [SUM_W-1:0]   hi;
  logic        [DUTY_W-1:0]  duty_pid;
  logic        [DUTY_W-1:0]  duty_next;

  assign hold_mode = (mode_r != MODE_NORMAL);

  always_comb begin
    e_ext = DIFF_W'(err_r);
    d1    = e_ext - DIFF_W'(err_prev);
    d2    = e_ext - (DIFF_W'(err_prev) <<< 1) + DIFF_W'(err_prev2);
    case (ctl.mul_sel)
      MUL_KP: begin
        mul_a = cfg.kp;
        mul_b = d1;
      end
      MUL_KI: begin
        mul_a = cfg.ki;
        mul_b = e_ext;
      end
      MUL_KD: begin
        mul_a = cfg.kd;
        mul_b = d2;
      end
      default: begin
        mul_a = cfg.kp;
        mul_b = d1;
      end
    endcase
  end

  always_comb begin
    smag = scaled[SCALE_W-1:GAIN_FRAC_BITS];
    if (neg) begin
      sat  = (smag > SAT_NEG) ? SAT_W'(SAT_NEG) : SAT_W'(smag);
      corr = SUM_W'(0) - $signed(SUM_W'(sat));
    end else begin
      sat  = (smag > SAT_POS) ? SAT_W'(SAT_POS) : SAT_W'(smag);
      corr = $signed(SUM_W'(sat));
    end
    sum = corr + $signed(SUM_W'(cfg.center));
    lo  = $signed(SUM_W'(cfg.left));
    hi  = $signed(SUM_W'(cfg.right));
    if (sum >= lo && sum <= hi) begin
      duty_pid = sum[DUTY_W-1:0];
    end else if (sum <= lo) begin
      duty_pid = cfg.left;
    end else begin
      duty_pid = cfg.right;
    end
    case (mode_r)
      MODE_NORMAL: duty_next = duty_pid;
      MODE_LEFT:   duty_next = cfg.left;
      default:     duty_next = cfg.right;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mode_r <= steer_mode;
      err_r  <= err_sample;
    end
    prod <= $signed({1'b0, mul_a}) * mul_b;
    case (ctl.acc_op)
      ACC_CLEAR: acc <= '0;
      ACC_ADD:   acc <= acc + ACC_W'(prod);
      default:   acc <= acc;
    endcase
    if (ctl.mag_en) begin
      neg <= acc[ACC_W-1];
      mag <= acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
    end
    if (ctl.scale_en) begin
      scaled <= SCALE_W'(mag) * SCALE_W'(band_gain(mag[MAG_W-1:GAIN_FRAC_BITS]));
    end
    if (ctl.fire) begin
      duty <= duty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_prev  <= '0;
      err_prev2 <= '0;
    end else if (ctl.fire && !hold_mode) begin
      err_prev2 <= err_prev;
      err_prev  <= err_r;
    end
  end

endmodule
`default_nettype wire

[sim/steering_duty_checker.sv]
// ----------------------------------------------------------------------------
// Steering duty checker
// Watches the input, result and register channels of the steering unit. Each
// accepted input transaction is run through a local model of the incremental
// PID path, and the predicted duty is queued. Each accepted result is compared
// with the oldest queued duty. The failure count and the number of duties
// still awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
module steering_duty_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [sisp_pkg::MODE_W-1:0]     steer_mode,
  input  logic [sisp_pkg::ERR_W-1:0]      err_sample,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [sisp_pkg::DUTY_W-1:0]     duty,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sisp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sisp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              duty_errors,
  output int                              duty_pending
);
  import sisp_pkg::*;

  logic [GAIN_W-1:0]       kp_q;
  logic [GAIN_W-1:0]       ki_q;
  logic [GAIN_W-1:0]       kd_q;
  logic [DUTY_W-1:0]       center_q;
  logic [DUTY_W-1:0]       left_q;
  logic [DUTY_W-1:0]       right_q;
  logic signed [ERR_W-1:0] err_recent;
  logic signed [ERR_W-1:0] err_older;
  logic [DUTY_W-1:0]       awaited_duty[$];
  logic [DUTY_W-1:0]       oldest;

  initial begin
    duty_errors  = 0;
    duty_pending = 0;
  end

  function automatic longint band_multiplier(input longint ipart);
    if (ipart <= 10) begin
      return 6;
    end else if (ipart <= 30) begin
      return 7;
    end else if (ipart <= 60) begin
      return 9;
    end
    return 10;
  endfunction

  function automatic logic [DUTY_W-1:0] steer_duty(input logic [MODE_W-1:0] mode,
                                                   input logic signed [ERR_W-1:0] e);
    longint d1;
    longint d2;
    longint v;
    longint mag;
    longint scaled;
    int     corr;
    int     total;
    int     lo;
    int     hi;
    if (mode == MODE_LEFT) begin
      return left_q;
    end else if (mode != MODE_NORMAL) begin
      return right_q;
    end
    d1 = longint'(e) - longint'(err_recent);
    d2 = longint'(e) - 2 * longint'(err_recent) + longint'(err_older);
    v = longint'(kp_q) * d1 + longint'(ki_q) * longint'(e) + longint'(kd_q) * d2;
    mag = (v < 0) ? -v : v;
    scaled = (mag * band_multiplier(mag >> GAIN_FRAC_BITS)) >> GAIN_FRAC_BITS;
    if (v < 0) begin
      corr = (scaled > 32768) ? -32768 : -int'(scaled);
    end else begin
      corr = (scaled > 32767) ? 32767 : int'(scaled);
    end
    total = corr + int'(center_q);
    lo = int'(left_q);
    hi = int'(right_q);
    if (total >= lo && total <= hi) begin
      return DUTY_W'(total);
    end else if (total <= lo) begin
      return left_q;
    end
    return right_q;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kp_q       <= KP_RESET;
      ki_q       <= KI_RESET;
      kd_q       <= KD_RESET;
      center_q   <= CENTER_RESET;
      left_q     <= LEFT_RESET;
      right_q    <= RIGHT_RESET;
      err_recent <= '0;
      err_older  <= '0;
      awaited_duty.delete();
      duty_pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_duty.size() == 0) begin
          $error("duty: expected no transaction, actual %0d", duty);
          duty_errors <= duty_errors + 1;
        end else begin
          oldest = awaited_duty.pop_front();
          if (duty !== oldest) begin
            $error("duty: expected %0d, actual %0d", oldest, duty);
            duty_errors <= duty_errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        awaited_duty.push_back(steer_duty(steer_mode, err_sample));
        if (steer_mode == MODE_NORMAL) begin
          err_older  <= err_recent;
          err_recent <= err_sample;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KP:     kp_q     <= cfg_data[GAIN_W-1:0];
          REG_KI:     ki_q     <= cfg_data[GAIN_W-1:0];
          REG_KD:     kd_q     <= cfg_data[GAIN_W-1:0];
          REG_CENTER: center_q <= cfg_data[DUTY_W-1:0];
          REG_LEFT:   left_q   <= cfg_data[DUTY_W-1:0];
          REG_RIGHT:  right_q  <= cfg_data[DUTY_W-1:0];
          default: begin
          end
        endcase
      end
      duty_pending <= awaited_duty.size();
    end
  end

endmodule

[sim/tb_servo_incremental_pid_steering_unit.sv]
// ----------------------------------------------------------------------------
// Servo incremental PID steering unit testbench
// Drives directed and random error samples through the steering unit under
// several gain, center and limit settings and several idle and stall patterns,
// including a long result hold-off. A checker module beside the unit predicts
// and compares every duty; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_servo_incremental_pid_steering_unit;
  import sisp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_RIGHT  = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_W'(3);

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic [MODE_W-1:0]     steer_mode = MODE_NORMAL;
  logic [ERR_W-1:0]      err_sample = '0;
  logic                  out_stall  = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_KP;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  wire                   in_stall;
  wire                   out_valid;
  wire                   cfg_ready;
  wire [DUTY_W-1:0]      duty;
  int                    duty_errors;
  int                    duty_pending;
  int                    idle_pct   = 0;
  int                    stall_pct  = 0;
  int                    hold_cycles = 0;

  servo_incremental_pid_steering_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .steer_mode (steer_mode),
    .err_sample (err_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .duty       (duty),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  steering_duty_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .steer_mode   (steer_mode),
    .err_sample   (err_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty         (duty),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .duty_errors  (duty_errors),
    .duty_pending (duty_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic offer(input logic [MODE_W-1:0] mode, input logic [ERR_W-1:0] err);
    in_valid   <= 1'b1;
    steer_mode <= mode;
    err_sample <= err;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (duty_pending == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd, input logic [DUTY_W-1:0] center,
                               input logic [DUTY_W-1:0] left, input logic [DUTY_W-1:0] right);
    write_reg(REG_KP, CFG_DATA_W'(kp));
    write_reg(REG_KI, CFG_DATA_W'(ki));
    write_reg(REG_KD, CFG_DATA_W'(kd));
    write_reg(REG_CENTER, CFG_DATA_W'(center));
    write_reg(REG_LEFT, CFG_DATA_W'(left));
    write_reg(REG_RIGHT, CFG_DATA_W'(right));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 98304));
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 15);
    if (r <= 10) begin
      return MODE_NORMAL;
    end else if (r <= 12) begin
      return MODE_LEFT;
    end else if (r <= 14) begin
      return MODE_RIGHT;
    end
    return MODE_UNUSED;
  endfunction

  function automatic logic [ERR_W-1:0] pick_err();
    case ($urandom_range(0, 5))
      0: return ERR_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2, 3: return ERR_W'(int'($urandom_range(0, 200)) - 100);
      4: return ERR_W'(int'($urandom_range(0, 4000)) - 2000);
      default: return ERR_W'(int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  initial begin
    logic [DUTY_W-1:0] lim_a;
    logic [DUTY_W-1:0] lim_b;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(MODE_LEFT, 16'h7FFF);
    offer(MODE_RIGHT, 16'h8000);
    offer(MODE_UNUSED, 16'h0000);
    offer(MODE_NORMAL, 16'h0000);
    offer(MODE_NORMAL, 16'h7FFF);
    offer(MODE_NORMAL, 16'h8000);
    offer(MODE_NORMAL, 16'h7FFF);
    offer(MODE_NORMAL, 16'hFFFF);
    offer(MODE_NORMAL, 16'h0001);

    settle();
    load_settings(20'd0, 20'd65536, 20'd0, 15'd16384, 15'd0, 15'd32767);
    offer(MODE_NORMAL, 16'd10);
    offer(MODE_NORMAL, 16'd11);
    offer(MODE_NORMAL, 16'd30);
    offer(MODE_NORMAL, 16'd31);
    offer(MODE_NORMAL, 16'd60);
    offer(MODE_NORMAL, 16'd61);
    offer(MODE_NORMAL, 16'd81);
    offer(MODE_NORMAL, -16'sd81);

    settle();
    load_settings(20'd65536, 20'd0, 20'd0, 15'd15000, 15'd20000, 15'd10000);
    offer(MODE_NORMAL, 16'h0000);
    offer(MODE_NORMAL, 16'h7FFF);
    offer(MODE_NORMAL, 16'h8000);
    offer(MODE_LEFT, 16'h1234);
    offer(MODE_RIGHT, 16'hEDCB);

    for (int p = 0; p < 8; p++) begin
      settle();
      if (p == 0) begin
        load_settings('1, '1, '1, '1, '0, '1);
      end else if (p == 1) begin
        load_settings('0, '0, '0, '1, '1, '1);
      end else begin
        lim_a = DUTY_W'($urandom);
        lim_b = DUTY_W'($urandom);
        if ($urandom_range(0, 7) != 0 && lim_a > lim_b) begin
          lim_a = lim_b;
          lim_b = DUTY_W'($urandom_range(lim_a, 32767));
        end
        load_settings(pick_gain(), pick_gain(), pick_gain(), DUTY_W'($urandom), lim_a, lim_b);
      end
      idle_pct  = (p % 4 == 1) ? 57 : (p % 4 == 3) ? 37 : 0;
      stall_pct = (p % 4 == 2) ? 57 : (p % 4 == 3) ? 37 : 0;
      for (int i = 0; i < 140; i++) begin
        if (p % 4 == 0 && i == 40) begin
          hold_cycles = 250;
        end
        if (i == 100) begin
          settle();
        end
        offer(pick_mode(), pick_err());
      end
    end

    settle();
    if (duty_errors == 0 && duty_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sisp_pkg.sv
hdl/sisp_ucode_rom.sv
hdl/sisp_sequencer.sv
hdl/sisp_datapath.sv
hdl/servo_incremental_pid_steering_unit.sv
sim/steering_duty_checker.sv
sim/tb_servo_incremental_pid_steering_unit.sv
